// ===== src/med_prediction_pixel_reconstruct_assert.svh =====
// Assertion macros for the MED pixel reconstruction block.
`ifndef MED_PREDICTION_PIXEL_RECONSTRUCT_ASSERT_SVH
`define MED_PREDICTION_PIXEL_RECONSTRUCT_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define MPRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mprc assertion failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define MPRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mprc assertion failed");

`endif

// ===== src/mprc_pkg.sv =====
// Types and constants shared by the MED pixel reconstruction block.
package mprc_pkg;

  localparam int VAL_W    = 32;  // stored reconstructed value
  localparam int RES_W    = 16;  // residual
  localparam int PIX_W    = 8;   // output pixel
  localparam int WIDTH_W  = 13;  // image_width register
  localparam int HEIGHT_W = 16;  // image_height register / row counter
  localparam int CFG_IDX_W = 1;
  localparam int Q        = 1;   // residual scale shift

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [PIX_W-1:0]    PIX_MAX      = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Position of the current pixel in the frame.
  typedef struct packed {
    logic first_row;
    logic first_col;
  } pos_t;

  // One output word.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             end_of_row;
    logic             end_of_frame;
  } result_t;

endpackage

// ===== src/mprc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mprc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mprc_recon.sv =====
// MED prediction, residual removal, 32-bit saturation and byte clamp.
module mprc_recon (
  input  logic signed [mprc_pkg::RES_W-1:0] residual_i,
  input  logic signed [mprc_pkg::VAL_W-1:0] left_i,
  input  logic signed [mprc_pkg::VAL_W-1:0] above_i,
  input  logic signed [mprc_pkg::VAL_W-1:0] diag_i,
  input  mprc_pkg::pos_t                    pos_i,
  output logic signed [mprc_pkg::VAL_W-1:0] value_o,
  output logic [mprc_pkg::PIX_W-1:0]        pixel_o
);

  localparam int MW = mprc_pkg::VAL_W + 2;  // med / a+b-c
  localparam int XW = mprc_pkg::VAL_W + 3;  // after subtracting 2*e

  logic signed [MW-1:0] a, b, c, med_v, lo, hi;
  logic signed [XW-1:0] e_x, e2, base, val;

  always_comb begin
    a = MW'(left_i);
    b = MW'(above_i);
    c = MW'(diag_i);
    lo = (a < b) ? a : b;
    hi = (a > b) ? a : b;
    if (c >= a && c >= b) begin
      med_v = lo;
    end else if (c <= a && c <= b) begin
      med_v = hi;
    end else begin
      med_v = a + b - c;
    end

    e_x = XW'(residual_i);
    e2  = e_x <<< mprc_pkg::Q;

    if (pos_i.first_row) begin
      base = XW'(a);
    end else if (pos_i.first_col) begin
      base = XW'(b);
    end else begin
      base = XW'(med_v);
    end

    val = (pos_i.first_row && pos_i.first_col) ? e_x : (base - e2);

    // saturate: top bits must all match the 32-bit sign bit
    if (val[XW-1:mprc_pkg::VAL_W-1] == '0 || val[XW-1:mprc_pkg::VAL_W-1] == '1) begin
      value_o = val[mprc_pkg::VAL_W-1:0];
    end else if (val[XW-1]) begin
      value_o = {1'b1, {(mprc_pkg::VAL_W-1){1'b0}}};
    end else begin
      value_o = {1'b0, {(mprc_pkg::VAL_W-1){1'b1}}};
    end

    if (value_o[mprc_pkg::VAL_W-1]) begin
      pixel_o = '0;
    end else if (|value_o[mprc_pkg::VAL_W-2:mprc_pkg::PIX_W]) begin
      pixel_o = mprc_pkg::PIX_MAX;
    end else begin
      pixel_o = value_o[mprc_pkg::PIX_W-1:0];
    end
  end

endmodule

// ===== src/mprc_oreg.sv =====
// Output register with skid entry so input and output stall independently.
module mprc_oreg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mprc_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mprc_pkg::result_t out_data_o
);

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  mprc_pkg::result_t main_q, main_d;
  mprc_pkg::result_t skid_q, skid_d;
  logic              push, pop;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;
  assign push = in_valid_i && in_ready_o;
  assign pop  = main_valid_q && out_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d = main_q;
    skid_d = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_q || pop) begin
        main_d = in_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d = in_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// ===== src/med_prediction_pixel_reconstruct.sv =====
// Top level: MED pixel reconstruction from a residual stream.
// An accepted word is registered in the output stage before it shows on m_axis.
// Throughput: one word per cycle while the output stage has room. The line store
// reads the next column, and the left value loops back through one MED/add path.
// Reset: counters, left/diag values and the output stage clear; image_width
// returns to 640 and image_height to 480. The line store is not cleared.
`include "med_prediction_pixel_reconstruct_assert.svh"

module med_prediction_pixel_reconstruct #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mprc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mprc_pkg::HEIGHT_W-1:0]       cfg_data_i,
  // residual input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mprc_pkg::RES_W-1:0]          s_axis_tdata,  // [15:0] residual
  // pixel output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mprc_pkg::PIX_W-1:0]          m_axis_tdata,  // [7:0] pixel
  output logic                                m_axis_tlast,  // end_of_row
  output logic                                m_axis_tuser   // end_of_frame
);

  localparam int CW    = $clog2(MAX_WIDTH);   // column index / line store address
  localparam int CNT_W = CW + 1;              // column compare, holds MAX_WIDTH
  localparam int RW    = mprc_pkg::HEIGHT_W + 1;

  // config registers
  logic [mprc_pkg::WIDTH_W-1:0]  width_q;
  logic [mprc_pkg::HEIGHT_W-1:0] height_q;

  // frame position and neighbor values
  logic [CW-1:0]                   col_q, col_d;
  logic [mprc_pkg::HEIGHT_W-1:0]   row_q, row_d;
  logic signed [mprc_pkg::VAL_W-1:0] left_q, diag_q;

  // same-address write/read bypass around the line store
  logic                            fwd_valid_q;
  logic [mprc_pkg::VAL_W-1:0]      fwd_data_q;
  logic [mprc_pkg::VAL_W-1:0]      ram_rdata;
  logic signed [mprc_pkg::VAL_W-1:0] above;

  logic                            in_acc;
  logic [CNT_W-1:0]                w_eff;
  logic [RW-1:0]                   h_eff;
  logic                            eor, eof;
  mprc_pkg::pos_t                  pos;
  logic signed [mprc_pkg::VAL_W-1:0] value;
  logic [mprc_pkg::PIX_W-1:0]      pixel;
  mprc_pkg::result_t               res, out_res;
  logic                            oreg_ready;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = oreg_ready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mprc_pkg::WIDTH_RESET;
      height_q <= mprc_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mprc_pkg::cfg_reg_e'(cfg_index_i))
        mprc_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[mprc_pkg::WIDTH_W-1:0];
        mprc_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective frame size: zero means one, width capped at the line store depth
  always_comb begin
    if (width_q == '0) begin
      w_eff = CNT_W'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(width_q);
    end
    h_eff = (height_q == '0) ? RW'(1) : RW'(height_q);
  end

  // a count already past a shrunk limit ends the row/frame here
  assign eor = (CNT_W'(col_q) + CNT_W'(1)) >= w_eff;
  assign eof = eor && ((RW'(row_q) + RW'(1)) >= h_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (eor) begin
        col_d = '0;
        row_d = eof ? '0 : row_q + mprc_pkg::HEIGHT_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  assign pos.first_row = (row_q == '0);
  assign pos.first_col = (col_q == '0);

  // line store: read address is the next column (col_d); read data matches col_q
  mprc_ram #(
    .WIDTH (mprc_pkg::VAL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (col_q),
    .wdata_i (value),
    .raddr_i (col_d),
    .rdata_o (ram_rdata)
  );

  assign above = fwd_valid_q ? fwd_data_q : ram_rdata;

  mprc_recon u_recon (
    .residual_i (s_axis_tdata),
    .left_i     (left_q),
    .above_i    (above),
    .diag_i     (diag_q),
    .pos_i      (pos),
    .value_o    (value),
    .pixel_o    (pixel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      diag_q      <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      // written column is read back next cycle (only with an effective width of one)
      fwd_valid_q <= in_acc && (col_q == col_d);
      if (in_acc) begin
        left_q <= value;
        if (!pos.first_row) begin
          diag_q <= above;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= value;
  end

  assign res.pixel        = pixel;
  assign res.end_of_row   = eor;
  assign res.end_of_frame = eof;

  mprc_oreg u_oreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (oreg_ready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = out_res.pixel;
  assign m_axis_tlast = out_res.end_of_row;
  assign m_axis_tuser = out_res.end_of_frame;

  // frame end is always a row end
  `MPRC_ASSERT_NOW(a_eof_is_eor, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  // row end returns the column to zero
  `MPRC_ASSERT_NEXT(a_col_wrap, in_acc && eor, col_q == '0)
  // mid-row word advances the column by one
  `MPRC_ASSERT_NEXT(a_col_step, in_acc && !eor, col_q == $past(col_q) + CW'(1))
  // frame end returns to the upper-left pixel
  `MPRC_ASSERT_NEXT(a_frame_wrap, in_acc && eof, row_q == '0 && col_q == '0)

endmodule
